FILE: rtl/qssd_pkg.sv
// Package for the query string splitter and decoder: payload types, codes and byte constants.
`timescale 1ns / 1ps
`default_nettype none

package qssd_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // Most results that one input byte can cause.
    localparam int MAX_RESULTS = 4;

    // Escape hold states.
    localparam logic [1:0] HELD_NONE    = 2'd0;
    localparam logic [1:0] HELD_PERCENT = 2'd1;
    localparam logic [1:0] HELD_DIGIT   = 2'd2;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       run_last;
    } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/query_string_split_and_decode.sv
// Top level of the streaming query string splitter and percent decoder.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Ports                       Payload
// -------  ---------  --------------------------  ---------------------------------
// s_       in         s_valid, s_ready, s_item    in_byte, end_of_string
// m_       out        m_valid, m_ready, m_item    kind, out_byte, run_last
//
// Each request is first caught in an input register. From there combinational
// decode logic turns it into zero to four results, which are written into a
// four-entry result queue together with the updated parse state. The queue then
// drains one result per cycle on the m_ channel while m_ready is high, so the rate
// is one request per cycle when each causes at most one result; after a request with
// more, the next request waits in the input register until only its last result is left.
// While results wait, the input register still takes the next request.
// Reset (aresetn low at a clock edge) empties both stages and returns the parse
// state to the key part with no pair seen and no escape held.
module query_string_split_and_decode (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire qssd_pkg::in_item_t s_item,
    output logic                 m_valid,
    input  wire                  m_ready,
    output qssd_pkg::out_item_t  m_item
);

    localparam int QD = qssd_pkg::MAX_RESULTS;
    localparam int CW = $clog2(QD + 1);

    // True for an ASCII hex digit of either case.
    function automatic logic is_hex(input logic [7:0] c);
        logic r;
        begin
            case (c) inside
                [8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]: r = 1'b1;
                default: r = 1'b0;
            endcase
            return r;
        end
    endfunction

    // Value of a hex digit; callers only pass digits.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        begin
            if (c <= 8'h39) begin
                d = c - 8'h30;
            end else if (c <= 8'h46) begin
                d = c - 8'h37;
            end else begin
                d = c - 8'h57;
            end
            return d[3:0];
        end
    endfunction

    // Input register.
    qssd_pkg::in_item_t  in_item_reg;
    logic                in_full_reg;

    // Parse state.
    logic       in_value_reg,  in_value_next;
    logic       pair_seen_reg, pair_seen_next;
    logic [1:0] held_count_reg, held_count_next;
    logic [7:0] held_digit_reg, held_digit_next;

    // Result queue: entry 0 is the head.
    qssd_pkg::out_item_t queue_reg [QD];
    logic [CW-1:0]       count_reg;

    qssd_pkg::out_item_t res_next [QD];
    logic [CW-1:0]       res_count;

    logic s_accept, m_pop, load_queue;

    assign m_valid    = (count_reg != '0);
    assign m_item     = queue_reg[0];
    assign m_pop      = m_valid && m_ready;
    // The queue takes a new batch when it is empty or its last entry leaves now.
    assign load_queue = in_full_reg &&
                        ((count_reg == '0) || ((count_reg == CW'(1)) && m_ready));
    assign s_ready    = !in_full_reg || load_queue;
    assign s_accept   = s_valid && s_ready;

    // Decode one request. The steps follow the order in which results appear;
    // each push appends one result to the batch.
    always_comb begin
        logic [7:0]    b;
        logic          last;
        logic [CW-1:0] n;
        logic [CW-1:0] idx;
        logic [1:0]    dk;
        b    = in_item_reg.in_byte;
        last = in_item_reg.end_of_string;
        n    = '0;
        for (int i = 0; i < QD; i++) begin
            res_next[i] = '{kind: qssd_pkg::KIND_KEY, out_byte: 8'h00, run_last: 1'b0};
        end
        in_value_next   = in_value_reg;
        pair_seen_next  = pair_seen_reg;
        held_count_next = held_count_reg;
        held_digit_next = held_digit_reg;

        if (b inside {qssd_pkg::CH_AMP, qssd_pkg::CH_SEMI}) begin
            // Flush held escape bytes, then close the pair if it had content.
            dk = in_value_next ? qssd_pkg::KIND_VALUE : qssd_pkg::KIND_KEY;
            if (held_count_next != qssd_pkg::HELD_NONE) begin
                res_next[n[1:0]] = '{kind: dk, out_byte: qssd_pkg::CH_PERCENT, run_last: 1'b0};
                n = n + CW'(1);
            end
            if (held_count_next == qssd_pkg::HELD_DIGIT) begin
                res_next[n[1:0]] = '{kind: dk, out_byte: held_digit_next, run_last: 1'b0};
                n = n + CW'(1);
            end
            held_count_next = qssd_pkg::HELD_NONE;
            held_digit_next = 8'h00;
            if (pair_seen_next) begin
                res_next[n[1:0]] = '{kind: qssd_pkg::KIND_END, out_byte: 8'h00,
                                     run_last: 1'b0};
                n = n + CW'(1);
            end
            in_value_next  = 1'b0;
            pair_seen_next = 1'b0;
        end else begin
            pair_seen_next = 1'b1;
            dk = in_value_next ? qssd_pkg::KIND_VALUE : qssd_pkg::KIND_KEY;
            if ((b == qssd_pkg::CH_EQUAL) && !in_value_next) begin
                if (held_count_next != qssd_pkg::HELD_NONE) begin
                    res_next[n[1:0]] = '{kind: dk, out_byte: qssd_pkg::CH_PERCENT,
                                         run_last: 1'b0};
                    n = n + CW'(1);
                end
                if (held_count_next == qssd_pkg::HELD_DIGIT) begin
                    res_next[n[1:0]] = '{kind: dk, out_byte: held_digit_next, run_last: 1'b0};
                    n = n + CW'(1);
                end
                held_count_next = qssd_pkg::HELD_NONE;
                held_digit_next = 8'h00;
                in_value_next   = 1'b1;
            end else if ((held_count_next == qssd_pkg::HELD_DIGIT) && is_hex(b)) begin
                // Complete escape.
                res_next[n[1:0]] = '{kind: dk,
                                     out_byte: {hex_val(held_digit_next), hex_val(b)},
                                     run_last: 1'b0};
                n = n + CW'(1);
                held_count_next = qssd_pkg::HELD_NONE;
                held_digit_next = 8'h00;
            end else if ((held_count_next == qssd_pkg::HELD_PERCENT) && is_hex(b)) begin
                held_count_next = qssd_pkg::HELD_DIGIT;
                held_digit_next = b;
            end else begin
                // A broken escape goes out as is; % opens a new one, + turns to space.
                if (held_count_next != qssd_pkg::HELD_NONE) begin
                    res_next[n[1:0]] = '{kind: dk, out_byte: qssd_pkg::CH_PERCENT,
                                         run_last: 1'b0};
                    n = n + CW'(1);
                end
                if (held_count_next == qssd_pkg::HELD_DIGIT) begin
                    res_next[n[1:0]] = '{kind: dk, out_byte: held_digit_next, run_last: 1'b0};
                    n = n + CW'(1);
                end
                held_count_next = qssd_pkg::HELD_NONE;
                held_digit_next = 8'h00;
                if (b == qssd_pkg::CH_PERCENT) begin
                    held_count_next = qssd_pkg::HELD_PERCENT;
                end else begin
                    res_next[n[1:0]] = '{kind: dk,
                                         out_byte: (b == qssd_pkg::CH_PLUS) ?
                                                   qssd_pkg::CH_SPACE : b,
                                         run_last: 1'b0};
                    n = n + CW'(1);
                end
            end
        end

        if (last) begin
            // End of string: flush what is held, close the pair, start over.
            dk = in_value_next ? qssd_pkg::KIND_VALUE : qssd_pkg::KIND_KEY;
            if (held_count_next != qssd_pkg::HELD_NONE) begin
                res_next[n[1:0]] = '{kind: dk, out_byte: qssd_pkg::CH_PERCENT, run_last: 1'b0};
                n = n + CW'(1);
            end
            if (held_count_next == qssd_pkg::HELD_DIGIT) begin
                res_next[n[1:0]] = '{kind: dk, out_byte: held_digit_next, run_last: 1'b0};
                n = n + CW'(1);
            end
            if (pair_seen_next) begin
                res_next[n[1:0]] = '{kind: qssd_pkg::KIND_END, out_byte: 8'h00,
                                     run_last: 1'b0};
                n = n + CW'(1);
            end
            in_value_next   = 1'b0;
            pair_seen_next  = 1'b0;
            held_count_next = qssd_pkg::HELD_NONE;
            held_digit_next = 8'h00;
        end

        idx = n - CW'(1);
        if (n != '0) begin
            res_next[idx[1:0]].run_last = 1'b1;
        end
        res_count = n;
    end

    // Input register and parse state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_full_reg    <= 1'b0;
            in_value_reg   <= 1'b0;
            pair_seen_reg  <= 1'b0;
            held_count_reg <= qssd_pkg::HELD_NONE;
            held_digit_reg <= 8'h00;
        end else begin
            if (s_accept) begin
                in_full_reg <= 1'b1;
            end else if (load_queue) begin
                in_full_reg <= 1'b0;
            end
            if (load_queue) begin
                in_value_reg   <= in_value_next;
                pair_seen_reg  <= pair_seen_next;
                held_count_reg <= held_count_next;
                held_digit_reg <= held_digit_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= s_item;
        end
    end

    // Result queue.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (load_queue) begin
            count_reg <= res_count;
        end else if (m_pop) begin
            count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load_queue) begin
            for (int i = 0; i < QD; i++) begin
                queue_reg[i] <= res_next[i];
            end
        end else if (m_pop) begin
            for (int i = 0; i < QD - 1; i++) begin
                queue_reg[i] <= queue_reg[i + 1];
            end
        end
    end

    // Assertions.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QD))
        else $error("result queue count out of range");

    a_run_last_at_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.run_last == (count_reg == CW'(1))))
        else $error("run_last does not mark the last queued result");

    a_end_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_item.kind == qssd_pkg::KIND_END)) |-> (m_item.out_byte == 8'h00))
        else $error("pair end carries a nonzero byte");

    a_string_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_queue && in_item_reg.end_of_string) |=>
            (!in_value_reg && !pair_seen_reg && (held_count_reg == qssd_pkg::HELD_NONE)))
        else $error("parse state not cleared after end of string");

    a_held_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (held_count_reg != 2'd3) && ((held_count_reg == qssd_pkg::HELD_NONE) ||
                                      pair_seen_reg))
        else $error("escape held outside of a pair");

endmodule

`default_nettype wire
